/* hdl/text_to_int64_parser_macros.svh */
// Assertion macros used by the parser's top level.
`ifndef TEXT_TO_INT64_PARSER_MACROS_SVH
`define TEXT_TO_INT64_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define T2I_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define T2I_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/t2i_pkg.sv */
// Shared types, constants and helper functions of the text to int64 parser.
package t2i_pkg;

  localparam int MAX_LEN = 4096;
  localparam int POS_W = 13;
  localparam int BASE_W = 6;
  localparam int DIGIT_W = 6;
  localparam int VAL_W = 64;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int REG_IDX_W = 1;
  localparam logic [DIGIT_W-1:0] NOT_DIGIT = '1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NUMBER_BASE,
    REG_SIGNED_MODE
  } reg_idx_e;

  typedef enum logic [1:0] {
    ERR_OK,
    ERR_BASE,
    ERR_RANGE
  } err_e;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              smode;
  } cfg_t;

  typedef struct packed {
    logic               last;
    logic               ws;
    logic               plus;
    logic               minus;
    logic               zero;
    logic               xchar;
    logic [DIGIT_W-1:0] digit;
  } tok_t;

  typedef struct packed {
    logic [VAL_W-1:0] acc;
    logic             minus;
    logic             ovf;
    logic             dseen;
    logic             base_ok;
    logic             smode;
    logic [POS_W-1:0] stop;
  } fin_t;

  function automatic logic radix_valid(input logic [BASE_W-1:0] r);
    return (r == '0) || (r >= BASE_W'(2) && r <= BASE_W'(36));
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
    logic [POS_W:0] s;
    s = {1'b0, p} + (POS_W + 1)'(1);
    return (s >= (POS_W + 1)'(MAX_LEN)) ? POS_W'(MAX_LEN) : s[POS_W-1:0];
  endfunction

endpackage

/* hdl/t2i_front.sv */
// Front end: configuration registers and byte classification.
module t2i_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [t2i_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [t2i_pkg::BASE_W-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            text_char_i,
  input  logic                  last_char_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output t2i_pkg::tok_t         q_tok_o,
  output t2i_pkg::cfg_t         cfg_o
);
  import t2i_pkg::*;

  cfg_t cfg_q;
  logic [DIGIT_W-1:0] digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base  <= BASE_W'(10);
      cfg_q.smode <= 1'b1;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_NUMBER_BASE: cfg_q.base  <= cfg_data_i;
        REG_SIGNED_MODE: cfg_q.smode <= cfg_data_i[0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    digit = NOT_DIGIT;
    if (text_char_i inside {[8'h30:8'h39]}) begin
      digit = DIGIT_W'(text_char_i - 8'h30);
    end else if (text_char_i inside {[8'h61:8'h7a]}) begin
      digit = DIGIT_W'(text_char_i - 8'h57);
    end else if (text_char_i inside {[8'h41:8'h5a]}) begin
      digit = DIGIT_W'(text_char_i - 8'h37);
    end
  end

  assign q_tok_o.last  = last_char_i;
  assign q_tok_o.ws    = (text_char_i inside {[8'd9:8'd13]}) || text_char_i == 8'd32;
  assign q_tok_o.plus  = text_char_i == 8'h2b;
  assign q_tok_o.minus = text_char_i == 8'h2d;
  assign q_tok_o.zero  = text_char_i == 8'h30;
  assign q_tok_o.xchar = text_char_i == 8'h78 || text_char_i == 8'h58;
  assign q_tok_o.digit = digit;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign cfg_o      = cfg_q;

endmodule

/* hdl/t2i_queue.sv */
// Short word queue between the front end and the parser.
module t2i_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  t2i_pkg::tok_t push_tok_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output t2i_pkg::tok_t head_o
);
  import t2i_pkg::*;

  tok_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] nxt(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= nxt(wr_q);
      end
      if (pop_i) begin
        rd_q <= nxt(rd_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

endmodule

/* hdl/t2i_parse.sv */
// Back end: per-string phase machine and saturating multiply-add.
module t2i_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  t2i_pkg::cfg_t cfg_i,
  input  logic          q_valid_i,
  input  t2i_pkg::tok_t q_tok_i,
  output logic          q_pop_o,
  input  logic          fin_ready_i,
  output logic          fin_valid_o,
  output t2i_pkg::fin_t fin_o
);
  import t2i_pkg::*;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [VAL_W-1:0]   acc_q, acc_d;
  logic               minus_q, minus_d;
  logic               ovf_q, ovf_d;
  logic               dseen_q, dseen_d;
  logic [BASE_W-1:0]  radix_q, radix_d;
  logic [POS_W-1:0]   pos_q, stop_q, stop_d;
  logic               live;
  logic [VAL_W+BASE_W-1:0] prod;
  logic               slot_free;
  logic               fin_valid_q;
  fin_t               fin_q;

  assign slot_free = !fin_valid_q || fin_ready_i;
  assign q_pop_o   = q_valid_i && (!q_tok_i.last || slot_free);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    minus_d = minus_q;
    ovf_d   = ovf_q;
    dseen_d = dseen_q;
    radix_d = radix_q;
    stop_d  = stop_q;
    live    = 1'b1;
    prod    = '0;
    if (pos_q == '0) begin
      radix_d = cfg_i.base;
      if (!radix_valid(cfg_i.base)) begin
        phase_d = PH_DONE;
      end
    end
    if (phase_d == PH_LEAD) begin
      if (q_tok_i.ws) begin
        live = 1'b0;
      end else if (q_tok_i.plus) begin
        phase_d = PH_START;
        live    = 1'b0;
      end else if (q_tok_i.minus) begin
        minus_d = 1'b1;
        phase_d = PH_START;
        live    = 1'b0;
      end else begin
        phase_d = PH_START;
      end
    end
    if (phase_d == PH_START && live) begin
      if (q_tok_i.zero && (radix_d == '0 || radix_d == BASE_W'(16))) begin
        phase_d = PH_ZERO;
        stop_d  = sat_inc(pos_q);
        live    = 1'b0;
      end else begin
        if (radix_d == '0) begin
          radix_d = BASE_W'(10);
        end
        phase_d = PH_DIGITS;
      end
    end
    if (phase_d == PH_ZERO && live) begin
      if (q_tok_i.xchar) begin
        radix_d = BASE_W'(16);
        phase_d = PH_DIGITS;
        live    = 1'b0;
      end else begin
        if (radix_d == '0) begin
          radix_d = BASE_W'(8);
        end
        dseen_d = 1'b1;
        acc_d   = '0;
        phase_d = PH_DIGITS;
      end
    end
    if (phase_d == PH_DIGITS && live) begin
      if (q_tok_i.digit >= radix_d || radix_d == '0) begin
        phase_d = PH_DONE;
      end else begin
        prod = (VAL_W + BASE_W)'(acc_d) * (VAL_W + BASE_W)'(radix_d)
             + (VAL_W + BASE_W)'(q_tok_i.digit);
        if (prod[VAL_W+BASE_W-1:VAL_W] != '0) begin
          ovf_d = 1'b1;
          acc_d = '1;
        end else begin
          acc_d = prod[VAL_W-1:0];
        end
        dseen_d = 1'b1;
        stop_d  = sat_inc(pos_q);
      end
    end
    if (q_tok_i.last && phase_d == PH_ZERO) begin
      dseen_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      acc_q       <= '0;
      minus_q     <= 1'b0;
      ovf_q       <= 1'b0;
      dseen_q     <= 1'b0;
      radix_q     <= '0;
      pos_q       <= '0;
      stop_q      <= '0;
      fin_valid_q <= 1'b0;
      fin_q       <= '0;
    end else begin
      if (q_pop_o && q_tok_i.last) begin
        fin_valid_q <= 1'b1;
      end else if (fin_ready_i) begin
        fin_valid_q <= 1'b0;
      end
      if (q_pop_o) begin
        if (q_tok_i.last) begin
          fin_q.acc     <= acc_d;
          fin_q.minus   <= minus_d;
          fin_q.ovf     <= ovf_d;
          fin_q.dseen   <= dseen_d;
          fin_q.base_ok <= radix_valid(radix_d);
          fin_q.smode   <= cfg_i.smode;
          fin_q.stop    <= stop_d;
          phase_q       <= PH_LEAD;
          acc_q         <= '0;
          minus_q       <= 1'b0;
          ovf_q         <= 1'b0;
          dseen_q       <= 1'b0;
          radix_q       <= '0;
          pos_q         <= '0;
          stop_q        <= '0;
        end else begin
          phase_q <= phase_d;
          acc_q   <= acc_d;
          minus_q <= minus_d;
          ovf_q   <= ovf_d;
          dseen_q <= dseen_d;
          radix_q <= radix_d;
          pos_q   <= sat_inc(pos_q);
          stop_q  <= stop_d;
        end
      end
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

endmodule

/* hdl/t2i_final.sv */
// Result stage: sign handling, range clamp and output register.
module t2i_final (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fin_valid_i,
  input  t2i_pkg::fin_t fin_i,
  output logic          fin_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [t2i_pkg::VAL_W-1:0] value_o,
  output logic [t2i_pkg::POS_W-1:0] end_position_o,
  output logic [1:0]    error_code_o
);
  import t2i_pkg::*;

  localparam logic [VAL_W-1:0] SMAX = {1'b0, {(VAL_W - 1){1'b1}}};
  localparam logic [VAL_W-1:0] SMIN = {1'b1, {(VAL_W - 1){1'b0}}};

  logic             valid_q;
  logic [VAL_W-1:0] value_q, value_d, neg;
  logic [POS_W-1:0] endp_q, endp_d;
  err_e             err_q, err_d;

  assign neg = '0 - fin_i.acc;

  always_comb begin
    value_d = fin_i.acc;
    err_d   = ERR_OK;
    endp_d  = fin_i.dseen ? fin_i.stop : '0;
    if (!fin_i.base_ok) begin
      value_d = '0;
      endp_d  = '0;
      err_d   = ERR_BASE;
    end else if (fin_i.smode) begin
      if (fin_i.ovf) begin
        err_d   = ERR_RANGE;
        value_d = fin_i.minus ? SMIN : SMAX;
      end else if (fin_i.minus) begin
        if (fin_i.acc > SMIN) begin
          err_d   = ERR_RANGE;
          value_d = SMIN;
        end else begin
          value_d = neg;
        end
      end else if (fin_i.acc > SMAX) begin
        err_d   = ERR_RANGE;
        value_d = SMAX;
      end
    end else begin
      if (fin_i.ovf) begin
        err_d   = ERR_RANGE;
        value_d = '1;
      end else if (fin_i.minus) begin
        value_d = neg;
      end
    end
  end

  assign fin_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      value_q <= '0;
      endp_q  <= '0;
      err_q   <= ERR_OK;
    end else if (fin_ready_o) begin
      valid_q <= fin_valid_i;
      if (fin_valid_i) begin
        value_q <= value_d;
        endp_q  <= endp_d;
        err_q   <= err_d;
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign value_o        = value_q;
  assign end_position_o = endp_q;
  assign error_code_o   = err_q;

endmodule

/* hdl/text_to_int64_parser.sv */
// Top level of the streaming text to 64-bit integer parser.
// Input channel: one string byte per word on text_char_i, last_char_i marks the
// final byte; in_valid_i/in_ready_o handshake. Output channel: one word per
// string (value_o, end_position_o, error_code_o) on out_valid_o/out_ready_i.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 number base, 1 signed mode); write only while no string is in flight.
// Throughput: one byte per cycle while in_ready_o is high, set by the parser's
// combinational 64x6 multiply-add with overflow check. A string's result goes
// from the queue through the parser's result register to the output register.
// A four-word queue separates byte intake from parsing, so input keeps
// flowing while a result waits. When the receiver stalls the result holds in
// the output register, the next result waits in the parser's result register,
// and the queue then fills and drops in_ready_o.
// Reset sets base 10 and signed mode, empties the queue and clears all
// per-string state.
module text_to_int64_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [t2i_pkg::REG_IDX_W-1:0] cfg_idx_i,
  input  logic [t2i_pkg::BASE_W-1:0]    cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_char_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [t2i_pkg::VAL_W-1:0] value_o,
  output logic [t2i_pkg::POS_W-1:0] end_position_o,
  output logic [1:0]  error_code_o
);
  import t2i_pkg::*;
  `include "text_to_int64_parser_macros.svh"

  cfg_t cfg;
  tok_t push_tok, head_tok;
  fin_t fin;
  logic q_full, q_push, q_valid, q_pop;
  logic fin_valid, fin_ready;

  t2i_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_char_i (text_char_i),
    .last_char_i (last_char_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_tok_o     (push_tok),
    .cfg_o       (cfg)
  );

  t2i_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_tok_i (push_tok),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_tok)
  );

  t2i_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_tok_i     (head_tok),
    .q_pop_o     (q_pop),
    .fin_ready_i (fin_ready),
    .fin_valid_o (fin_valid),
    .fin_o       (fin)
  );

  t2i_final u_final (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fin_valid_i    (fin_valid),
    .fin_i          (fin),
    .fin_ready_o    (fin_ready),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_o        (value_o),
    .end_position_o (end_position_o),
    .error_code_o   (error_code_o)
  );

  `T2I_ASSERT_NXT(a_fin_hold, fin_valid && !fin_ready, fin_valid && $stable(fin.acc), "pending result lost")
  `T2I_ASSERT_IMP(a_base_err_zero, out_valid_o && error_code_o == ERR_BASE, value_o == '0 && end_position_o == '0, "invalid base result not zero")
  `T2I_ASSERT_IMP(a_pos_bound, out_valid_o, end_position_o <= POS_W'(MAX_LEN), "end position past limit")
  `T2I_ASSERT_IMP(a_stall_full, !in_ready_o, q_valid, "input stalled with empty queue")

endmodule
